// ----- rtl/wsd_pkg.sv -----
// Package for the windowed standstill detector: sizes, codes, state type,
// compare-unit structs and ring index helper. No dependencies.
`default_nettype none

package wsd_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = CNT_W + 1;   // holds ring sums up to 2*DEPTH-1

  localparam int TIME_W = 48;
  localparam int VEL_W  = 24;
  localparam int REG_W  = 32;
  localparam int SQ_W   = 2 * VEL_W;
  localparam int AGE_W  = TIME_W + 1;
  localparam int CIDX_W = 4;

  localparam int AXES  = 3;
  localparam int AX_W  = 2;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_WINDOW = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_LIMIT  = CIDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MACC,
    ST_WRITE,
    ST_PR_RD,
    ST_PR_CMP,
    ST_QO_RD,
    ST_QO_CMP,
    ST_Q_RD,
    ST_Q_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] stamp_us;
    logic [REG_W-1:0]  thr_us;
  } age_req_t;

  typedef struct packed {
    logic gt;   // age >  threshold
    logic ge;   // age >= threshold
  } age_res_t;

  // Reduce a value below 2*DEPTH to a ring index.
  function automatic logic [PTR_W-1:0] wrap_idx(input logic [XW-1:0] v);
    logic [XW-1:0] r;
    r = (v >= XW'(DEPTH)) ? (v - XW'(DEPTH)) : v;
    return r[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wsd_ifs.sv -----
// Channel interfaces for the standstill detector (input, result, config).
// Depends on wsd_pkg.
`default_nettype none

interface wsd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [wsd_pkg::TIME_W-1:0]  now_us;
  logic [wsd_pkg::TIME_W-1:0]  sample_stamp_us;
  logic signed [wsd_pkg::VEL_W-1:0] vel_x;
  logic signed [wsd_pkg::VEL_W-1:0] vel_y;
  logic signed [wsd_pkg::VEL_W-1:0] vel_z;
  logic [wsd_pkg::REG_W-1:0]   hold_us;

  modport source (output valid, action, now_us, sample_stamp_us, vel_x, vel_y, vel_z,
                  hold_us, input ready);
  modport sink   (input valid, action, now_us, sample_stamp_us, vel_x, vel_y, vel_z,
                  hold_us, output ready);
endinterface

interface wsd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       stopped;
  logic [wsd_pkg::CNT_W-1:0]  entries;

  modport source (output valid, stopped, entries, input ready);
  modport sink   (input valid, stopped, entries, output ready);
endinterface

interface wsd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wsd_pkg::CIDX_W-1:0]  reg_index;
  logic [wsd_pkg::REG_W-1:0]   data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/wsd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module wsd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output      logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_age_cmp.sv -----
// Shared age unit: signed age = now - stamp, compared against a threshold.
// Depends on wsd_pkg.
`default_nettype none

module wsd_age_cmp (
  input  wire wsd_pkg::age_req_t req,
  output      wsd_pkg::age_res_t res
);

  logic signed [wsd_pkg::AGE_W-1:0] age;
  logic signed [wsd_pkg::AGE_W-1:0] thr;

  assign age = signed'({1'b0, req.now_us}) - signed'({1'b0, req.stamp_us});
  assign thr = signed'(wsd_pkg::AGE_W'(req.thr_us));

  assign res.gt = (age > thr);
  assign res.ge = (age >= thr);

endmodule

`default_nettype wire

// ----- rtl/windowed_standstill_detector.sv -----
// Top level of the windowed standstill detector: sequencer, squaring datapath,
// history ring in wsd_ram, shared age compare in wsd_age_cmp.
// Depends on wsd_pkg, wsd_ifs, wsd_ram, wsd_age_cmp.
//
//  channel  | dir | transaction carries
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | action, now_us, sample_stamp_us, vel_x/y/z, hold_us
//  out_ch   | out | stopped, entries (one per input transaction)
//  cfg_ch   | in  | reg_index, data (window_us, still_limit_sq); always ready
//
// An add squares the axes, writes the sample, then prunes, examining
// 1..DEPTH entries; a query walks up to DEPTH entries, or goes straight to
// DONE on an empty store. Each entry takes a read state, then a compare
// state: the registered read of the history RAM feeds the shared age compare.
// Reset (rst_n low, synchronous) empties the history and loads register
// defaults; the RAM is not cleared, only held entries are ever read.
// A stalled result waits in the output register while the next transaction is
// taken in and worked; that one then holds in DONE, with in_ch not ready,
// until the output register frees up.
`default_nettype none

module windowed_standstill_detector (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wsd_in_if.sink      in_ch,
  wsd_out_if.source   out_ch,
  wsd_cfg_if.sink     cfg_ch
);

  localparam int RW = wsd_pkg::TIME_W + 1;   // stamp + moving flag

  wsd_pkg::state_t state_r, state_nxt;

  // control state
  logic [wsd_pkg::PTR_W-1:0] newest_r, newest_nxt;
  logic [wsd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [wsd_pkg::AX_W-1:0]  sel_r, sel_nxt;
  logic [wsd_pkg::CNT_W-1:0] qk_r, qk_nxt;
  logic                      stop_r, stop_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // config registers
  logic [wsd_pkg::REG_W-1:0] window_r;
  logic [wsd_pkg::REG_W-1:0] limit_r;

  // payload
  logic [wsd_pkg::SQ_W-1:0]   acc_r, acc_nxt;
  logic [wsd_pkg::SQ_W-1:0]   prod_r, prod_nxt;
  logic                       out_stop_r, out_stop_nxt;
  logic [wsd_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [wsd_pkg::TIME_W-1:0] now_r;
  logic [wsd_pkg::TIME_W-1:0] stamp_r;
  logic [wsd_pkg::VEL_W-1:0]  vel_r [wsd_pkg::AXES];
  logic [wsd_pkg::REG_W-1:0]  hold_r;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == wsd_pkg::ST_IDLE);

  // ring addressing
  logic [wsd_pkg::PTR_W-1:0] oldest_idx;
  logic [wsd_pkg::PTR_W-1:0] walk_idx;
  logic [wsd_pkg::PTR_W-1:0] next_newest;

  assign oldest_idx = wsd_pkg::wrap_idx(wsd_pkg::XW'(newest_r) + wsd_pkg::XW'(wsd_pkg::DEPTH)
                                        + wsd_pkg::XW'(1) - wsd_pkg::XW'(cnt_r));
  assign walk_idx   = wsd_pkg::wrap_idx(wsd_pkg::XW'(newest_r) + wsd_pkg::XW'(wsd_pkg::DEPTH)
                                        - wsd_pkg::XW'(qk_r));
  assign next_newest = wsd_pkg::wrap_idx(wsd_pkg::XW'(newest_r) + wsd_pkg::XW'(1));

  // history RAM
  logic                      ram_we;
  logic [wsd_pkg::PTR_W-1:0] ram_raddr;
  logic [RW-1:0]             ram_wdata;
  logic [RW-1:0]             ram_rdata;
  logic                      rd_moving;

  assign rd_moving = ram_rdata[0];

  wsd_ram #(
    .W (RW),
    .D (wsd_pkg::DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_newest),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared age compare: window while pruning, hold while querying
  wsd_pkg::age_req_t age_req;
  wsd_pkg::age_res_t age_res;

  assign age_req.now_us   = now_r;
  assign age_req.stamp_us = ram_rdata[RW-1:1];
  assign age_req.thr_us   = (state_r == wsd_pkg::ST_PR_CMP) ? window_r : hold_r;

  wsd_age_cmp u_age (
    .req (age_req),
    .res (age_res)
  );

  // shared squarer: one axis per cycle, product registered before the add
  logic [wsd_pkg::VEL_W-1:0] cur_vel;
  logic [wsd_pkg::VEL_W-1:0] cur_mag;
  logic                      moving;

  assign cur_vel = vel_r[sel_r];
  assign cur_mag = cur_vel[wsd_pkg::VEL_W-1] ? (~cur_vel + wsd_pkg::VEL_W'(1)) : cur_vel;
  assign moving  = (acc_r >= wsd_pkg::SQ_W'(limit_r));
  assign ram_wdata = {stamp_r, moving};

  logic last_walk;
  assign last_walk = ((qk_r + wsd_pkg::CNT_W'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wsd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == wsd_pkg::ACT_QUERY) begin
            state_nxt = (cnt_r == '0) ? wsd_pkg::ST_DONE : wsd_pkg::ST_QO_RD;
          end else begin
            state_nxt = wsd_pkg::ST_MUL;
          end
        end
      end
      wsd_pkg::ST_MUL: begin
        if (sel_r == wsd_pkg::AX_W'(wsd_pkg::AXES - 1)) state_nxt = wsd_pkg::ST_MACC;
      end
      wsd_pkg::ST_MACC:  state_nxt = wsd_pkg::ST_WRITE;
      wsd_pkg::ST_WRITE: state_nxt = wsd_pkg::ST_PR_RD;
      wsd_pkg::ST_PR_RD: state_nxt = wsd_pkg::ST_PR_CMP;
      wsd_pkg::ST_PR_CMP: begin
        if (age_res.gt && (cnt_r != wsd_pkg::CNT_W'(1))) state_nxt = wsd_pkg::ST_PR_RD;
        else state_nxt = wsd_pkg::ST_DONE;
      end
      wsd_pkg::ST_QO_RD: state_nxt = wsd_pkg::ST_QO_CMP;
      wsd_pkg::ST_QO_CMP: begin
        state_nxt = age_res.ge ? wsd_pkg::ST_Q_RD : wsd_pkg::ST_DONE;
      end
      wsd_pkg::ST_Q_RD: state_nxt = wsd_pkg::ST_Q_CMP;
      wsd_pkg::ST_Q_CMP: begin
        if (rd_moving || age_res.ge || last_walk) state_nxt = wsd_pkg::ST_DONE;
        else state_nxt = wsd_pkg::ST_Q_RD;
      end
      wsd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = wsd_pkg::ST_IDLE;
      end
      default: state_nxt = wsd_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    newest_nxt    = newest_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    qk_nxt        = qk_r;
    stop_nxt      = stop_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_stop_nxt  = out_stop_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_raddr     = oldest_idx;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      wsd_pkg::ST_IDLE: begin
        sel_nxt  = '0;
        qk_nxt   = '0;
        stop_nxt = 1'b0;
        acc_nxt  = '0;
        prod_nxt = '0;
      end
      wsd_pkg::ST_MUL: begin
        prod_nxt = cur_mag * cur_mag;
        acc_nxt  = acc_r + prod_r;
        sel_nxt  = sel_r + wsd_pkg::AX_W'(1);
      end
      wsd_pkg::ST_MACC: begin
        acc_nxt = acc_r + prod_r;
      end
      wsd_pkg::ST_WRITE: begin
        ram_we     = 1'b1;
        newest_nxt = next_newest;
        if (cnt_r != wsd_pkg::CNT_W'(wsd_pkg::DEPTH)) cnt_nxt = cnt_r + wsd_pkg::CNT_W'(1);
      end
      wsd_pkg::ST_PR_RD: begin
        ram_raddr = oldest_idx;
      end
      wsd_pkg::ST_PR_CMP: begin
        if (age_res.gt) cnt_nxt = cnt_r - wsd_pkg::CNT_W'(1);
      end
      wsd_pkg::ST_QO_RD: begin
        ram_raddr = oldest_idx;
      end
      wsd_pkg::ST_QO_CMP: begin
        // oldest entry old enough: tentatively stopped, walk decides
        stop_nxt = age_res.ge;
      end
      wsd_pkg::ST_Q_RD: begin
        ram_raddr = walk_idx;
      end
      wsd_pkg::ST_Q_CMP: begin
        if (rd_moving) stop_nxt = 1'b0;
        qk_nxt = qk_r + wsd_pkg::CNT_W'(1);
      end
      wsd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_stop_nxt  = stop_r;
          out_cnt_nxt   = cnt_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsd_pkg::ST_IDLE;
      newest_r    <= '0;
      cnt_r       <= '0;
      sel_r       <= '0;
      qk_r        <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      qk_r        <= qk_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // config registers; an unknown index is dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= wsd_pkg::REG_W'(2000000);
      limit_r  <= wsd_pkg::REG_W'(100);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        wsd_pkg::CFG_WINDOW: window_r <= cfg_ch.data;
        wsd_pkg::CFG_LIMIT:  limit_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_stop_r <= out_stop_nxt;
    out_cnt_r  <= out_cnt_nxt;
    if (in_acc) begin
      now_r    <= in_ch.now_us;
      stamp_r  <= in_ch.sample_stamp_us;
      vel_r[0] <= in_ch.vel_x;
      vel_r[1] <= in_ch.vel_y;
      vel_r[2] <= in_ch.vel_z;
      hold_r   <= in_ch.hold_us;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.stopped = out_stop_r;
  assign out_ch.entries = out_cnt_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wsd_pkg::CNT_W'(wsd_pkg::DEPTH))
    else $error("held count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != wsd_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting a transaction");

  a_stop_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_r) |-> (out_cnt_r != '0))
    else $error("stopped reported with an empty history");

  a_add_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == wsd_pkg::ST_WRITE) && (cnt_r != wsd_pkg::CNT_W'(wsd_pkg::DEPTH)))
      |=> (cnt_r == ($past(cnt_r) + wsd_pkg::CNT_W'(1))))
    else $error("add did not grow history by one");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for windowed_standstill_detector: directed table, then random phases
// checked by an in-bench predictor. Depends on wsd_pkg, the wsd_*_if interfaces
// and the detector RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int QUIET_LIMIT    = 4000;          // cycles with no transaction at all
  localparam int HOLDOFF_CYCLES = 500;           // long receiver stall under pressure
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;

  localparam logic [TIME_W-1:0] T_MAX    = {TIME_W{1'b1}};
  localparam logic [REG_W-1:0]  REG_MAX  = {REG_W{1'b1}};
  localparam logic [VEL_W-1:0]  VEL_MAX  = {1'b0, {VEL_W-1{1'b1}}};
  localparam logic [VEL_W-1:0]  VEL_MIN  = {1'b1, {VEL_W-1{1'b0}}};
  localparam logic [REG_W-1:0]  WINDOW_RST = 32'd2000000;
  localparam logic [REG_W-1:0]  LIMIT_RST  = 32'd100;
  // No register lives at this index; writes to it must be dropped.
  localparam logic [CIDX_W-1:0] CFG_UNUSED = {CIDX_W{1'b1}};

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                    action;
    logic [TIME_W-1:0]       now_us;
    logic [TIME_W-1:0]       stamp_us;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [REG_W-1:0]        hold_us;
  } sample_t;

  typedef struct packed {
    logic             stopped;
    logic [CNT_W-1:0] entries;
  } verdict_t;

  // Hand-written expectation for a directed row; chk = 0 means use the predictor.
  typedef struct packed {
    bit       chk;
    verdict_t v;
  } typed_t;

  typedef struct packed {
    sample_t s;
    typed_t  t;
  } dir_row_t;

  typedef struct packed {
    int          idle_pct;
    int          stall_pct;
    logic [31:0] window_us;
    logic [31:0] limit_sq;
    int          items;
    bit          pressure;
    bit          stray_write;
    bit          rand_regs;
  } phase_t;

  // ---------------------------------------------------------------------------
  // Directed table. Default registers: window 2 s, limit 100 (1 mm/s squared).
  // ---------------------------------------------------------------------------
  localparam int N_DIR = 23;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // query on an empty store straight after reset
    '{'{ACT_QUERY, 48'd0,    48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b1, '{1'b0, 7'd0}}},
    // first still sample
    '{'{ACT_ADD,   48'd1000, 48'd1000, 24'sd0,  24'sd0,  24'sd0, REG_MAX}, '{1'b1, '{1'b0, 7'd1}}},
    '{'{ACT_QUERY, 48'd1000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    // just below the speed limit, then exactly at it (moving)
    '{'{ACT_ADD,   48'd2000, 48'd2000, 24'sd9,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    '{'{ACT_ADD,   48'd3000, 48'd3000, 24'sd10, 24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd4000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    // negative components
    '{'{ACT_ADD,   48'd5000, 48'd5000, -24'sd6, -24'sd6, -24'sd6, 32'd0}, '{1'b0, '0}},
    '{'{ACT_ADD,   48'd6000, 48'd6000, 24'sd5,  -24'sd5, 24'sd5, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd6000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd500}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd6000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd6000, 48'd0,    24'sd0,  24'sd0,  24'sd0, REG_MAX}, '{1'b0, '0}},
    // sample stamped in the future
    '{'{ACT_ADD,   48'd7000, 48'd9000, 24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd7000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b0, '0}},
    // velocity extremes
    '{'{ACT_ADD,   48'd8000, 48'd8000, VEL_MIN, VEL_MIN, VEL_MIN, 32'd0}, '{1'b0, '0}},
    '{'{ACT_ADD,   48'd8000, 48'd0,    VEL_MAX, VEL_MAX, VEL_MAX, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd8000, 48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd1}, '{1'b0, '0}},
    // window expires the oldest few
    '{'{ACT_ADD,   48'd2008000, 48'd2008000, 24'sd0, 24'sd0, 24'sd0, 32'd0}, '{1'b0, '0}},
    // everything, new sample included, pruned away
    '{'{ACT_ADD,   T_MAX,    48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b1, '{1'b0, 7'd0}}},
    '{'{ACT_QUERY, T_MAX,    48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b1, '{1'b0, 7'd0}}},
    // stamp far in the future: negative age is kept and never reaches hold
    '{'{ACT_ADD,   48'd0,    T_MAX,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b1, '{1'b0, 7'd1}}},
    '{'{ACT_QUERY, 48'd0,    48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd0}, '{1'b1, '{1'b0, 7'd1}}},
    '{'{ACT_ADD,   48'd0,    48'd0,    24'sd1,  24'sd1,  24'sd1, 32'd0}, '{1'b0, '0}},
    '{'{ACT_QUERY, 48'd100,  48'd0,    24'sd0,  24'sd0,  24'sd0, 32'd100}, '{1'b0, '0}}
  };

  // Random phases: idling mix, register settings, length, pressure, stray write, random registers.
  localparam int N_PHASES = 8;
  localparam phase_t PHASES [N_PHASES] = '{
    '{0,  0,  32'd2000000, 32'd100,   350, 1'b0, 1'b0, 1'b0},
    '{86, 0,  REG_MAX,     32'd5000,  300, 1'b0, 1'b0, 1'b0},
    '{0,  86, 32'd0,       REG_MAX,   150, 1'b0, 1'b1, 1'b0},
    '{26, 26, 32'd300000,  32'd0,     200, 1'b0, 1'b0, 1'b0},
    '{0,  0,  32'd2000000, 32'd400,   250, 1'b1, 1'b0, 1'b0},
    '{86, 0,  32'd1000000, 32'd100,   250, 1'b0, 1'b0, 1'b0},
    '{0,  86, 32'd0,       32'd0,     200, 1'b0, 1'b0, 1'b1},
    '{26, 26, 32'd2000000, 32'd100,   200, 1'b0, 1'b1, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  wsd_in_if  in_if ();
  wsd_out_if out_if ();
  wsd_cfg_if cfg_if ();

  windowed_standstill_detector u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: history ring, pointers, registers
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] hist_stamp [DEPTH];
  bit                hist_moving [DEPTH];
  int unsigned       newest_slot = 0;
  int unsigned       held_cnt    = 0;
  logic [REG_W-1:0]  window_reg  = WINDOW_RST;
  logic [REG_W-1:0]  limit_reg   = LIMIT_RST;

  verdict_t    expected_verdicts [$];
  int unsigned mismatches = 0;

  // Knobs shared between the stimulus and the receiver/sender processes.
  int     idle_pct    = 0;
  int     stall_pct   = 0;
  bit     holdoff_req = 1'b0;
  typed_t check_tag;                  // travels with the item on in_if

  // Traffic generator state
  logic [TIME_W-1:0] track_us;
  bit                in_motion;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint vel_sq(input logic signed [VEL_W-1:0] v);
    return longint'(v) * longint'(v);
  endfunction

  // Signed age of a held sample; both operands zero-extended, so exact.
  function automatic longint age_at(input logic [TIME_W-1:0] now, input int unsigned slot);
    return longint'(now) - longint'(hist_stamp[slot]);
  endfunction

  function automatic int unsigned oldest_slot();
    return (newest_slot + DEPTH + 1 - held_cnt) % DEPTH;
  endfunction

  function automatic verdict_t judge_standstill(input sample_t s);
    verdict_t    v;
    longint      speed_sq;
    longint      hold;
    int unsigned slot;
    v.stopped = 1'b0;
    if (s.action == ACT_ADD) begin
      speed_sq = vel_sq(s.vel_x) + vel_sq(s.vel_y) + vel_sq(s.vel_z);
      newest_slot = (newest_slot + 1) % DEPTH;
      hist_stamp[newest_slot]  = s.stamp_us;
      hist_moving[newest_slot] = (speed_sq >= longint'(limit_reg));
      if (held_cnt < DEPTH) held_cnt++;
      // drop from the old end until the oldest fits the window (or none left)
      while (held_cnt > 0 && age_at(s.now_us, oldest_slot()) > longint'(window_reg))
        held_cnt--;
    end else begin
      hold = longint'(s.hold_us);
      if (held_cnt > 0 && age_at(s.now_us, oldest_slot()) >= hold) begin
        v.stopped = 1'b1;
        // newest to oldest; the first sample old enough is still checked
        for (int k = 0; k < int'(held_cnt); k++) begin
          slot = (newest_slot + DEPTH - k) % DEPTH;
          if (hist_moving[slot]) begin
            v.stopped = 1'b0;
            break;
          end
          if (age_at(s.now_us, slot) >= hold) break;
        end
      end
    end
    v.entries = CNT_W'(held_cnt);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: every transaction is observed at the clock edge that accepts it
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, msg);  // keep log short
  endtask

  always @(posedge clk) begin : scoreboard
    verdict_t want;
    verdict_t model;
    sample_t  seen;
    if (rst_n) begin
      // result side first: a result never belongs to an item accepted this edge
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.stopped !== want.stopped)
            report_mismatch($sformatf("stopped %0b, expected %0b",
                                      out_if.stopped, want.stopped));
          if (out_if.entries !== want.entries)
            report_mismatch($sformatf("entries %0d, expected %0d",
                                      out_if.entries, want.entries));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.reg_index)
          CFG_WINDOW: window_reg = cfg_if.data;
          CFG_LIMIT:  limit_reg  = cfg_if.data;
          default: ;  // unknown index: ignored
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        seen.action   = in_if.action;
        seen.now_us   = in_if.now_us;
        seen.stamp_us = in_if.sample_stamp_us;
        seen.vel_x    = in_if.vel_x;
        seen.vel_y    = in_if.vel_y;
        seen.vel_z    = in_if.vel_z;
        seen.hold_us  = in_if.hold_us;
        model = judge_standstill(seen);   // always run: keeps the history in step
        expected_verdicts.push_back(check_tag.chk ? check_tag.v : model);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on any channel
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------
  // Offer one item; returns in the step right after the accepting edge.
  task automatic offer(input sample_t s, input typed_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.action          <= s.action;
    in_if.now_us          <= s.now_us;
    in_if.sample_stamp_us <= s.stamp_us;
    in_if.vel_x           <= s.vel_x;
    in_if.vel_y           <= s.vel_y;
    in_if.vel_z           <= s.vel_z;
    in_if.hold_us         <= s.hold_us;
    check_tag             <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.data      <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [REG_W-1:0] win, input logic [REG_W-1:0] lim,
                              input bit stray);
    if (stray) write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_LIMIT, lim);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly a plausible odometry stream with runs of standing
  // still and of moving, queries against recent time; a little pure noise.
  // ---------------------------------------------------------------------------
  function automatic logic signed [VEL_W-1:0] pick_vel(input bit moving);
    logic signed [VEL_W-1:0] v;
    int unsigned             sel;
    sel = $urandom_range(9);
    if (!moving && sel < 9)
      v = VEL_W'($urandom_range(0, 8)) - VEL_W'(4);      // creeping, under the limit
    else if (sel < 6)
      v = VEL_W'($urandom_range(0, 400)) - VEL_W'(200);  // around typical limits
    else if (sel < 8)
      v = VEL_W'($urandom);
    else
      v = sel[0] ? VEL_MAX : VEL_MIN;
    return v;
  endfunction

  function automatic sample_t next_sample();
    sample_t     s;
    int unsigned roll;
    // start from all-random fields; don't-care fields stay random
    s.action   = 1'($urandom);
    s.now_us   = {16'($urandom), 32'($urandom)};
    s.stamp_us = {16'($urandom), 32'($urandom)};
    s.vel_x    = VEL_W'($urandom);
    s.vel_y    = VEL_W'($urandom);
    s.vel_z    = VEL_W'($urandom);
    s.hold_us  = $urandom;
    roll = $urandom_range(99);
    if (roll < 3) begin
      // noise; half the time keep now near the stream so history survives
      if ($urandom_range(1) == 0) s.now_us = track_us + TIME_W'($urandom_range(0, 100000));
      return s;
    end
    if ($urandom_range(9) == 0) in_motion = !in_motion;
    if (roll < 70) begin
      s.action = ACT_ADD;
      track_us += ($urandom_range(3) == 0) ? TIME_W'($urandom_range(0, 400000))
                                           : TIME_W'($urandom_range(1000, 40000));
      s.now_us = track_us;
      if ($urandom_range(7) == 0)
        s.stamp_us = track_us + TIME_W'($urandom_range(0, 5000));   // stamped ahead
      else
        s.stamp_us = track_us - TIME_W'($urandom_range(0, 5000));
      s.vel_x = pick_vel(in_motion);
      s.vel_y = pick_vel(in_motion);
      s.vel_z = pick_vel(in_motion);
    end else begin
      s.action = ACT_QUERY;
      s.now_us = track_us + TIME_W'($urandom_range(0, 20000));
      case ($urandom_range(7))
        0:       s.hold_us = '0;
        1:       ;                                          // full 32-bit range
        2:       s.hold_us = $urandom_range(0, 3000000);
        default: s.hold_us = $urandom_range(0, 200000);
      endcase
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [REG_W-1:0] win;
    logic [REG_W-1:0] lim;
    typed_t           no_tag;

    no_tag = '0;
    // every DUT input known from time zero
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.action          <= ACT_ADD;
    in_if.now_us          <= '0;
    in_if.sample_stamp_us <= '0;
    in_if.vel_x           <= '0;
    in_if.vel_y           <= '0;
    in_if.vel_z           <= '0;
    in_if.hold_us         <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.reg_index      <= CFG_WINDOW;
    cfg_if.data           <= '0;
    check_tag             <= '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    track_us  = {2'b00, 14'($urandom), 32'($urandom)} + TIME_W'(4000000);
    in_motion = 1'b0;

    // directed table, reset register values, no idling
    foreach (DIRECTED[i]) offer(DIRECTED[i].s, DIRECTED[i].t);
    settle();

    // random phases; registers change only with the block drained
    foreach (PHASES[p]) begin
      win = PHASES[p].window_us;
      lim = PHASES[p].limit_sq;
      if (PHASES[p].rand_regs) begin
        win = $urandom_range(50000, 5000000);
        lim = $urandom_range(0, 20000);
      end
      program_regs(win, lim, PHASES[p].stray_write);
      idle_pct  = PHASES[p].idle_pct;
      stall_pct = PHASES[p].stall_pct;
      // long receiver hold-off while items keep coming: the input must back up
      if (PHASES[p].pressure) holdoff_req = 1'b1;
      for (int n = 0; n < PHASES[p].items; n++) offer(next_sample(), no_tag);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
